/* design/rmst_pkg.sv */
// shared types and constants for the range-minimum segment tree
package rmst_pkg;

	localparam int DATA_W = 32;

	// largest signed 32-bit value, the identity of the minimum
	localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

	// opcode field codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// operations of the shared compare unit
	// merge compares the right accumulator against the left one
	typedef enum logic [2:0] {
		MIN_NOP,
		MIN_INIT,
		MIN_LOAD_L,
		MIN_ACC_L,
		MIN_ACC_R,
		MIN_MERGE
	} min_op_t;

	// command from the sequencer to the compare unit
	typedef struct packed {
		min_op_t                   op;
		logic signed [DATA_W-1:0]  operand;
	} min_cmd_t;

endpackage

/* design/rmst_node_ram.sv */
// single-port node memory with registered read data
module rmst_node_ram #(
	parameter int ADDR_W = 11
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [ADDR_W-1:0]                  addr,
	input  logic signed [rmst_pkg::DATA_W-1:0] wdata,
	output logic signed [rmst_pkg::DATA_W-1:0] rdata
);

	logic signed [rmst_pkg::DATA_W-1:0] mem_q [2**ADDR_W];
	logic signed [rmst_pkg::DATA_W-1:0] rdata_q;

	// one access per cycle, read data valid on the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* design/rmst_min_unit.sv */
// shared signed minimum unit with left and right accumulators
module rmst_min_unit (
	input  logic                               clk,
	input  rmst_pkg::min_cmd_t                 cmd,
	output logic signed [rmst_pkg::DATA_W-1:0] res
);

	logic signed [rmst_pkg::DATA_W-1:0] lv_q;
	logic signed [rmst_pkg::DATA_W-1:0] rv_q;
	logic signed [rmst_pkg::DATA_W-1:0] acc_sel;
	logic signed [rmst_pkg::DATA_W-1:0] operand_sel;

	// the one comparator: accumulator against operand, or right against left on merge
	always_comb begin
		acc_sel     = (cmd.op == rmst_pkg::MIN_ACC_R || cmd.op == rmst_pkg::MIN_MERGE) ?
			rv_q : lv_q;
		operand_sel = (cmd.op == rmst_pkg::MIN_MERGE) ? lv_q : cmd.operand;
		res         = (acc_sel < operand_sel) ? acc_sel : operand_sel;
	end

	// accumulator update
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rmst_pkg::MIN_INIT: begin
				lv_q <= rmst_pkg::MAX_VALUE;
				rv_q <= rmst_pkg::MAX_VALUE;
			end
			rmst_pkg::MIN_LOAD_L: lv_q <= cmd.operand;
			rmst_pkg::MIN_ACC_L:  lv_q <= res;
			rmst_pkg::MIN_ACC_R:  rv_q <= res;
			default: begin
			end
		endcase
	end

endmodule

/* design/range_minimum_segment_tree_unit.sv */
// top level of the range-minimum segment tree: sequencer, handshakes, output register
//
// Input channel (in_valid/in_ready) carries opcode, index_or_left and value_or_right.
// A write transaction replaces one entry and produces nothing; a write with an
// index of LEAF_COUNT or more is dropped. A query transaction produces exactly one
// range_minimum on the output channel (out_valid/out_ready); an empty range, a
// negative right bound, or a left bound past the clamped right bound gives 2147483647.
// One item is worked on at a time; in_ready is high only when the sequencer is idle.
// Sequence, with L = log2 of LEAF_COUNT rounded up to a power of two:
//   write: the leaf is written on acceptance, then a sibling read and a parent write
//          per level; in_ready returns once the walk reaches the root
//   query: up to L + 1 loop rounds of two states (left, right), then loop exit, drain
//          and final compare; in_ready returns with out_valid; an empty query goes
//          straight to the final compare
// The node memory has one port, so each node read and each node write takes its own state.
// After reset a clearing pass writes 2147483647 into all 2*2^L nodes, one per cycle
// (2048 nodes at the default size); in_ready stays low meanwhile.
// A finished result sits in the output register; while the receiver stalls, new
// writes are still taken, and a following query waits at its final step.
module range_minimum_segment_tree_unit #(
	parameter int LEAF_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [9:0]         index_or_left,
	input  logic signed [31:0] value_or_right,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] range_minimum
);

	localparam int PAD_LOG = $clog2(LEAF_COUNT);
	localparam int NODE_W  = PAD_LOG + 1;
	localparam int AW      = PAD_LOG + 2;
	localparam logic [AW-1:0] PAD_A    = AW'(2**PAD_LOG);
	localparam logic [AW-1:0] ROOT_A   = AW'(1);
	localparam logic [31:0]   LEAF_CNT = 32'(LEAF_COUNT);
	localparam logic [31:0]   LAST_IDX = 32'(LEAF_COUNT - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_Q_L,
		ST_Q_R,
		ST_Q_DRAIN,
		ST_Q_FIN
	} state_t;

	state_t                 state_q;
	logic [NODE_W-1:0]      clr_q;
	logic [AW-1:0]          l_q;
	logic [AW-1:0]          r_q;
	logic                   rd_pend_s1;
	rmst_pkg::min_op_t      rd_op_s1;
	logic                   out_valid_q;
	logic signed [31:0]     range_minimum_q;

	logic                   in_fire;
	logic [31:0]            idx_ext;
	logic [31:0]            right_c;
	logic                   q_empty;
	logic                   wr_ok;
	logic [AW-1:0]          leaf_l;
	logic [AW-1:0]          leaf_r;
	logic [AW-1:0]          r_dec;
	logic                   rd_issue;
	rmst_pkg::min_op_t      rd_op;
	logic                   fin_go;

	logic                   ram_we;
	logic [NODE_W-1:0]      ram_addr;
	logic signed [31:0]     ram_wdata;
	logic signed [31:0]     ram_rdata;
	rmst_pkg::min_cmd_t     min_cmd;
	logic signed [31:0]     min_res;

	rmst_node_ram #(
		.ADDR_W(NODE_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	rmst_min_unit u_min (
		.clk(clk),
		.cmd(min_cmd),
		.res(min_res)
	);

	// input decode: leaf addresses and range checks
	always_comb begin
		idx_ext = 32'(index_or_left);
		right_c = ($unsigned(value_or_right) > LAST_IDX) ? LAST_IDX : $unsigned(value_or_right);
		q_empty = value_or_right[31] || (idx_ext > right_c);
		wr_ok   = idx_ext < LEAF_CNT;
		leaf_l  = AW'(idx_ext) + PAD_A;
		leaf_r  = AW'(right_c) + PAD_A + ROOT_A;
		r_dec   = r_q - ROOT_A;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_go   = (state_q == ST_Q_FIN) && (!out_valid_q || out_ready);

	// memory port and compare unit steering
	always_comb begin
		ram_we          = 1'b0;
		ram_addr        = l_q[NODE_W-1:0];
		ram_wdata       = rmst_pkg::MAX_VALUE;
		rd_issue        = 1'b0;
		rd_op           = rmst_pkg::MIN_ACC_L;
		min_cmd.op      = rmst_pkg::MIN_NOP;
		min_cmd.operand = ram_rdata;
		// read data returning from the previous cycle
		if (rd_pend_s1) begin
			min_cmd.op = rd_op_s1;
		end
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (opcode == rmst_pkg::OP_WRITE) begin
						if (wr_ok) begin
							ram_we          = 1'b1;
							ram_addr        = leaf_l[NODE_W-1:0];
							ram_wdata       = value_or_right;
							min_cmd.op      = rmst_pkg::MIN_LOAD_L;
							min_cmd.operand = value_or_right;
						end
					end else begin
						min_cmd.op = rmst_pkg::MIN_INIT;
					end
				end
			end
			ST_UPD_RD: begin
				ram_addr = l_q[NODE_W-1:0] ^ NODE_W'(1);
			end
			ST_UPD_WR: begin
				min_cmd.op = rmst_pkg::MIN_ACC_L;
				ram_we     = 1'b1;
				ram_wdata  = min_res;
			end
			ST_Q_L: begin
				if ((l_q < r_q) && l_q[0]) begin
					rd_issue = 1'b1;
					rd_op    = rmst_pkg::MIN_ACC_L;
				end
			end
			ST_Q_R: begin
				ram_addr = r_dec[NODE_W-1:0];
				if (r_q[0]) begin
					rd_issue = 1'b1;
					rd_op    = rmst_pkg::MIN_ACC_R;
				end
			end
			ST_Q_DRAIN: begin
			end
			ST_Q_FIN: begin
				min_cmd.op = rmst_pkg::MIN_MERGE;
			end
			default: begin
			end
		endcase
	end

	// final compare: right accumulator against left accumulator
	logic signed [31:0] rv_tap;
	assign rv_tap = min_res;

	// sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_pend_s1  <= 1'b0;
			rd_op_s1    <= rmst_pkg::MIN_ACC_L;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			rd_op_s1   <= rd_op;
			// result register: load on the final step, clear once taken
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (opcode == rmst_pkg::OP_WRITE) begin
							if (wr_ok) begin
								l_q     <= leaf_l;
								state_q <= ST_UPD_RD;
							end
						end else if (q_empty) begin
							state_q <= ST_Q_FIN;
						end else begin
							l_q     <= leaf_l;
							r_q     <= leaf_r;
							state_q <= ST_Q_L;
						end
					end
				end
				ST_UPD_RD: begin
					if (l_q == ROOT_A) begin
						state_q <= ST_IDLE;
					end else begin
						l_q     <= l_q >> 1;
						state_q <= ST_UPD_WR;
					end
				end
				ST_UPD_WR: begin
					state_q <= ST_UPD_RD;
				end
				ST_Q_L: begin
					if (l_q < r_q) begin
						if (l_q[0]) begin
							l_q <= l_q + ROOT_A;
						end
						state_q <= ST_Q_R;
					end else begin
						state_q <= ST_Q_DRAIN;
					end
				end
				ST_Q_R: begin
					l_q     <= l_q >> 1;
					r_q     <= (r_q[0] ? r_dec : r_q) >> 1;
					state_q <= ST_Q_L;
				end
				ST_Q_DRAIN: begin
					state_q <= ST_Q_FIN;
				end
				ST_Q_FIN: begin
					if (fin_go) begin
						range_minimum_q <= rv_tap;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign range_minimum = range_minimum_q;

`ifndef SYNTHESIS
	// the query walk keeps the left bound at or below the right bound
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_L) |-> (l_q <= r_q))
		else $error("query bounds crossed");

	// node reads are only outstanding during a query walk
	a_pend_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_Q_L || state_q == ST_Q_R || state_q == ST_Q_DRAIN))
		else $error("node read outstanding outside query");

	// the final compare never starts with a read still in flight
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_FIN) |-> !rd_pend_s1)
		else $error("final compare with pending read");

	// a result appears only out of the final query step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_Q_FIN))
		else $error("result without a query");

	// the update walk never writes above the root
	a_upd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR) |-> (l_q != '0))
		else $error("update walked past root");
`endif

endmodule
